// File: design/cpts_pkg.sv
// Shared definitions for the counter/priority task scheduler.
// Field widths, request, status and unit operation codes, and control structs.
// No dependencies.
package cpts_pkg;

  localparam int NUM_SLOTS_DEF    = 64;
  localparam int COUNTER_BITS_DEF = 9;

  localparam int REQ_W   = 2;
  localparam int TIME_W  = 32;
  localparam int SECS_W  = 16;
  localparam int SLOT_W  = 6;
  localparam int PRIO_W  = 8;
  localparam int STAT_W  = 2;
  localparam int MS_W    = 10;
  localparam int PROD_W  = SECS_W + MS_W;
  localparam int IN_W    = REQ_W + TIME_W + SECS_W + SLOT_W + PRIO_W;
  localparam int OUT_W   = 8;

  localparam logic [MS_W-1:0] MS_PER_SEC = MS_W'(1000);

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SLEEP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_EXIT  = 2'd3;

  // Task status.
  localparam logic [STAT_W-1:0] ST_RUN   = 2'd0;
  localparam logic [STAT_W-1:0] ST_SLEEP = 2'd1;
  localparam logic [STAT_W-1:0] ST_EXIT  = 2'd2;

  // Operations of the slot update unit.
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_SLEEP = 3'd1;
  localparam logic [2:0] OP_LOAD  = 3'd2;
  localparam logic [2:0] OP_EXIT  = 3'd3;
  localparam logic [2:0] OP_WAKE  = 3'd4;
  localparam logic [2:0] OP_RCH   = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic       slot_vld;
    logic       best_found;
  } alu_ctl_t;

  typedef struct packed {
    logic we;
    logic cand;
    logic better;
    logic tick_more;
  } alu_res_t;

endpackage

// File: design/cpts_slot_mem.sv
// Slot table memory: one write port and one registered read port.
// Holds status, counter, priority and wake time of every task slot.
// No dependencies.
module cpts_slot_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 51,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/cpts_slot_alu.sv
// Shared slot update unit: per-entry tick, sleep, load, exit, wake and recharge,
// plus the counter compare used for the best-task search.
// Depends on cpts_pkg.
module cpts_slot_alu #(
  parameter int COUNTER_BITS = cpts_pkg::COUNTER_BITS_DEF
) (
  input  cpts_pkg::alu_ctl_t                                   ctl,
  input  logic [cpts_pkg::STAT_W+COUNTER_BITS+cpts_pkg::PRIO_W+cpts_pkg::TIME_W-1:0] ent_i,
  input  logic [cpts_pkg::TIME_W-1:0]                          now_i,
  input  logic [cpts_pkg::PROD_W-1:0]                          prod_i,
  input  logic [cpts_pkg::PRIO_W-1:0]                          prio_i,
  input  logic [COUNTER_BITS-1:0]                              best_cnt_i,
  output logic [cpts_pkg::STAT_W+COUNTER_BITS+cpts_pkg::PRIO_W+cpts_pkg::TIME_W-1:0] ent_o,
  output cpts_pkg::alu_res_t                                   res_o
);

  localparam int CB    = COUNTER_BITS;
  localparam int SUM_W = ((CB > cpts_pkg::PRIO_W) ? CB : cpts_pkg::PRIO_W) + 1;
  localparam logic [SUM_W-1:0] CNT_MAX = SUM_W'((1 << CB) - 1);

  logic [cpts_pkg::STAT_W-1:0] st, st_n;
  logic [CB-1:0]               cnt, cnt_n;
  logic [cpts_pkg::PRIO_W-1:0] pr, pr_n, prio_fix;
  logic [cpts_pkg::TIME_W-1:0] wk, wk_n;
  logic [SUM_W-1:0]            rch_sum, load_sum;
  logic [CB-1:0]               rch_cnt, load_cnt;
  logic                        tick_more;
  logic                        we;

  assign st = ent_i[cpts_pkg::STAT_W-1:0];
  assign cnt = ent_i[CB+1:2];
  assign pr  = ent_i[CB+9:CB+2];
  assign wk  = ent_i[CB+41:CB+10];

  assign prio_fix  = (prio_i == '0) ? cpts_pkg::PRIO_W'(1) : prio_i;
  assign rch_sum   = SUM_W'(cnt >> 1) + SUM_W'(pr);
  assign load_sum  = SUM_W'(prio_fix);
  assign rch_cnt   = (rch_sum > CNT_MAX) ? CNT_MAX[CB-1:0] : rch_sum[CB-1:0];
  assign load_cnt  = (load_sum > CNT_MAX) ? CNT_MAX[CB-1:0] : load_sum[CB-1:0];
  assign tick_more = ctl.slot_vld && (cnt > CB'(1));

  always_comb begin
    st_n  = st;
    cnt_n = cnt;
    pr_n  = pr;
    wk_n  = wk;
    we    = 1'b0;
    case (ctl.op)
      cpts_pkg::OP_TICK: begin
        we    = ctl.slot_vld;
        cnt_n = tick_more ? (cnt - CB'(1)) : '0;
      end
      cpts_pkg::OP_SLEEP: begin
        we   = 1'b1;
        wk_n = now_i + cpts_pkg::TIME_W'(prod_i);
        st_n = cpts_pkg::ST_SLEEP;
      end
      cpts_pkg::OP_LOAD: begin
        we    = 1'b1;
        st_n  = cpts_pkg::ST_RUN;
        pr_n  = prio_fix;
        cnt_n = load_cnt;
        wk_n  = '0;
      end
      cpts_pkg::OP_EXIT: begin
        we   = 1'b1;
        st_n = cpts_pkg::ST_EXIT;
      end
      cpts_pkg::OP_WAKE: begin
        we = ctl.slot_vld;
        if (ctl.slot_vld && (st != cpts_pkg::ST_EXIT) && (now_i > wk)) begin
          st_n = cpts_pkg::ST_RUN;
        end
      end
      cpts_pkg::OP_RCH: begin
        we    = ctl.slot_vld;
        cnt_n = rch_cnt;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign ent_o = {wk_n, pr_n, cnt_n, st_n};

  // The search sees the status and counter as they are after this update.
  assign res_o.we        = we;
  assign res_o.cand      = ctl.slot_vld && (st_n == cpts_pkg::ST_RUN);
  assign res_o.better    = res_o.cand && (!ctl.best_found || (cnt_n > best_cnt_i));
  assign res_o.tick_more = tick_more;

endmodule

// File: design/counter_priority_task_scheduler_unit.sv
// Top level of the counter/priority task scheduler: request sequencer, slot valid bits,
// best-task search registers and output register.
// Depends on cpts_pkg, cpts_slot_mem and cpts_slot_alu.

// One request is worked on at a time; in_tready is high only while the sequencer is idle,
// and a result may still wait in the output register while the next request is taken.
// A load, an exit, or a tick that leaves the counter above zero goes from S_UPD straight to
// S_RES for its result. A request that runs the scheduler sweeps the slot table once
// through the single read port of the slot memory, one slot per cycle, for wake-up and
// selection; when a runnable slot is found but every runnable counter is zero, a second
// sweep recharges the counters and selects again. After reset the state, the current slot,
// the valid bits and out_tvalid are cleared; the slot memory is not, with no clearing pass.
module counter_priority_task_scheduler_unit #(
  parameter int NUM_SLOTS    = cpts_pkg::NUM_SLOTS_DEF,
  parameter int COUNTER_BITS = cpts_pkg::COUNTER_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // req_type[1:0], now_ms[33:2], sleep_seconds[49:34], slot[55:50], task_priority[63:56]
  input  logic [cpts_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // next_slot[5:0], switched[6], none_runnable[7]
  output logic [cpts_pkg::OUT_W-1:0] out_tdata
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int CB    = COUNTER_BITS;
  localparam int ENT_W = cpts_pkg::STAT_W + CB + cpts_pkg::PRIO_W + cpts_pkg::TIME_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_WAKE = 3'd2;
  localparam logic [2:0] S_RCH  = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [cpts_pkg::REQ_W-1:0]  in_req;
  logic [cpts_pkg::TIME_W-1:0] in_now;
  logic [cpts_pkg::SECS_W-1:0] in_secs;
  logic [cpts_pkg::SLOT_W-1:0] in_slot;
  logic [cpts_pkg::PRIO_W-1:0] in_prio;
  logic [31:0]                 in_slot32;
  logic [IDX_W-1:0]            in_idx;
  logic                        in_inrange;
  logic                        accept;

  logic [2:0]                  state_r, state_nxt;
  logic [cpts_pkg::REQ_W-1:0]  req_r, req_nxt;
  logic [cpts_pkg::TIME_W-1:0] now_r, now_nxt;
  logic [cpts_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [cpts_pkg::PRIO_W-1:0] prio_r, prio_nxt;
  logic [IDX_W-1:0]            tgt_r, tgt_nxt;
  logic                        inrange_r, inrange_nxt;
  logic [IDX_W-1:0]            cur_r, cur_nxt;
  logic [NUM_SLOTS-1:0]        valid_r, valid_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        proc_vld_r, proc_vld_nxt;
  logic [IDX_W-1:0]            proc_idx_r, proc_idx_nxt;
  logic                        found_r, found_nxt;
  logic [IDX_W-1:0]            best_r, best_nxt;
  logic [CB-1:0]               best_cnt_r, best_cnt_nxt;
  logic [cpts_pkg::SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic                        res_sw_r, res_sw_nxt;
  logic                        res_none_r, res_none_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;
  logic [cpts_pkg::OUT_W-1:0]  out_tdata_r, out_tdata_nxt;

  logic                        sweep;
  logic                        issue;
  logic [31:0]                 cur32, best32;
  logic [IDX_W-1:0]            rd_addr, wr_addr;
  logic                        mem_we;
  logic [ENT_W-1:0]            rd_data, alu_ent;
  cpts_pkg::alu_ctl_t          alu_ctl;
  cpts_pkg::alu_res_t          alu_res;

  assign in_req  = in_tdata[1:0];
  assign in_now  = in_tdata[33:2];
  assign in_secs = in_tdata[49:34];
  assign in_slot = in_tdata[55:50];
  assign in_prio = in_tdata[63:56];

  assign in_slot32  = 32'(in_slot);
  assign in_idx     = in_slot32[IDX_W-1:0];
  assign in_inrange = in_slot32 < 32'(NUM_SLOTS);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign sweep  = (state_r == S_WAKE) || (state_r == S_RCH);
  assign issue  = cnt_r < CNT_W'(NUM_SLOTS);
  assign cur32  = 32'(cur_r);
  assign best32 = 32'(best_r);

  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = (in_req == cpts_pkg::REQ_EXIT) ? in_idx : cur_r;
    end else begin
      rd_addr = cnt_r[IDX_W-1:0];
    end
  end

  always_comb begin
    alu_ctl.best_found = found_r;
    if (sweep) begin
      alu_ctl.op       = (state_r == S_WAKE) ? cpts_pkg::OP_WAKE : cpts_pkg::OP_RCH;
      alu_ctl.slot_vld = valid_r[proc_idx_r];
    end else begin
      alu_ctl.slot_vld = valid_r[tgt_r];
      case (req_r)
        cpts_pkg::REQ_TICK:  alu_ctl.op = cpts_pkg::OP_TICK;
        cpts_pkg::REQ_SLEEP: alu_ctl.op = cpts_pkg::OP_SLEEP;
        cpts_pkg::REQ_LOAD:  alu_ctl.op = cpts_pkg::OP_LOAD;
        default:             alu_ctl.op = cpts_pkg::OP_EXIT;
      endcase
    end
  end

  assign wr_addr = sweep ? proc_idx_r : tgt_r;
  assign mem_we  = ((state_r == S_UPD) && alu_res.we && inrange_r) ||
                   (sweep && proc_vld_r && alu_res.we);

  cpts_slot_mem #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (ENT_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (alu_ent),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  cpts_slot_alu #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_alu (
    .ctl        (alu_ctl),
    .ent_i      (rd_data),
    .now_i      (now_r),
    .prod_i     (prod_r),
    .prio_i     (prio_r),
    .best_cnt_i (best_cnt_r),
    .ent_o      (alu_ent),
    .res_o      (alu_res)
  );

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    now_nxt        = now_r;
    prod_nxt       = prod_r;
    prio_nxt       = prio_r;
    tgt_nxt        = tgt_r;
    inrange_nxt    = inrange_r;
    cur_nxt        = cur_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    proc_vld_nxt   = proc_vld_r;
    proc_idx_nxt   = proc_idx_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_cnt_nxt   = best_cnt_r;
    res_slot_nxt   = res_slot_r;
    res_sw_nxt     = res_sw_r;
    res_none_nxt   = res_none_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt  = in_req;
          now_nxt  = in_now;
          prod_nxt = cpts_pkg::PROD_W'(in_secs) * cpts_pkg::PROD_W'(cpts_pkg::MS_PER_SEC);
          prio_nxt = in_prio;
          if ((in_req == cpts_pkg::REQ_LOAD) || (in_req == cpts_pkg::REQ_EXIT)) begin
            tgt_nxt     = in_idx;
            inrange_nxt = in_inrange;
          end else begin
            tgt_nxt     = cur_r;
            inrange_nxt = 1'b1;
          end
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        res_slot_nxt = cur32[cpts_pkg::SLOT_W-1:0];
        res_sw_nxt   = 1'b0;
        res_none_nxt = 1'b0;
        cnt_nxt      = '0;
        proc_vld_nxt = 1'b0;
        found_nxt    = 1'b0;
        best_cnt_nxt = '0;
        state_nxt    = S_RES;
        case (req_r)
          cpts_pkg::REQ_TICK: begin
            if (!alu_res.tick_more) begin
              state_nxt = S_WAKE;
            end
          end
          cpts_pkg::REQ_SLEEP: begin
            state_nxt = S_WAKE;
          end
          cpts_pkg::REQ_LOAD: begin
            if (inrange_r) begin
              valid_nxt[tgt_r] = 1'b1;
            end
          end
          default: begin
            state_nxt = S_RES;
          end
        endcase
      end
      S_WAKE, S_RCH: begin
        proc_vld_nxt = issue;
        proc_idx_nxt = cnt_r[IDX_W-1:0];
        if (issue) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (proc_vld_r && alu_res.better) begin
          found_nxt    = 1'b1;
          best_nxt     = proc_idx_r;
          best_cnt_nxt = alu_ent[CB+1:2];
        end
        if (!issue && !proc_vld_r) begin
          if ((state_r == S_WAKE) && found_r && (best_cnt_r == '0)) begin
            // Every runnable counter is spent: recharge all valid slots and pick again.
            cnt_nxt      = '0;
            found_nxt    = 1'b0;
            best_cnt_nxt = '0;
            state_nxt    = S_RCH;
          end else begin
            res_sw_nxt = 1'b1;
            if (found_r) begin
              res_slot_nxt = best32[cpts_pkg::SLOT_W-1:0];
              res_none_nxt = 1'b0;
              cur_nxt      = best_r;
            end else begin
              res_slot_nxt = '0;
              res_none_nxt = 1'b1;
            end
            state_nxt = S_RES;
          end
        end
      end
      S_RES: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {res_none_r, res_sw_r, res_slot_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_r        <= '0;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      valid_r      <= valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    now_r       <= now_nxt;
    prod_r      <= prod_nxt;
    prio_r      <= prio_nxt;
    tgt_r       <= tgt_nxt;
    inrange_r   <= inrange_nxt;
    cnt_r       <= cnt_nxt;
    proc_vld_r  <= proc_vld_nxt;
    proc_idx_r  <= proc_idx_nxt;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    best_cnt_r  <= best_cnt_nxt;
    res_slot_r  <= res_slot_nxt;
    res_sw_r    <= res_sw_nxt;
    res_none_r  <= res_none_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: design/cpts_checker.sv
// Port-level checks for the counter/priority task scheduler and their bind.
// Depends on cpts_pkg and counter_priority_task_scheduler_unit.
module cpts_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [cpts_pkg::IN_W-1:0]  in_tdata,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [cpts_pkg::OUT_W-1:0] out_tdata
);

  // A result that is not taken stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in progress");

  // Finding no runnable task is only reported by a scheduling decision.
  a_none_needs_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] |-> out_tdata[6])
    else $error("none_runnable without switched");

  // With no runnable task the chosen slot reads as zero.
  a_none_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] |-> out_tdata[5:0] == 6'd0)
    else $error("none_runnable with nonzero next_slot");

  // Request payload must be known when a request is offered; only the request kind is checked.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid |-> !$isunknown(in_tdata[1:0]))
    else $error("unknown request kind");

endmodule

bind counter_priority_task_scheduler_unit cpts_checker u_cpts_checker (.*);
